// ===== rtl/fbmvn_pkg.sv =====
package fbmvn_pkg;

   // defaults for the top-level parameters
   localparam int OCTAVES_DEF     = 4;
   localparam int COORD_WIDTH_DEF = 24;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SCALE = 2'd1;

   localparam logic [31:0] SEED_RESET  = 32'd0;
   localparam logic [15:0] SCALE_RESET = 16'd1311;

   // pipeline stage numbers
   localparam int ST_IN      = 0;  // request register
   localparam int ST_POS     = 1;  // grid * scale
   localparam int ST_HASH    = 2;  // lattice index, hash seed mix
   localparam int ST_SQR     = 3;  // n*n, t^2
   localparam int ST_POLY    = 4;  // n*n*15731 + 789221, t^3
   localparam int ST_CORNER  = 5;  // corner values, t^4
   localparam int ST_T5      = 6;  // t^5
   localparam int ST_FADE    = 7;  // quintic fade
   localparam int ST_XMUL    = 8;  // s_x * (b - a)
   localparam int ST_XADD    = 9;  // row blends
   localparam int ST_ZMUL    = 10; // s_z * (r1 - r0)
   localparam int ST_ZADD    = 11; // octave noise
   localparam int ST_OUT     = 12; // summed, clamped height
   localparam int NUM_STAGES = 13;

   // lattice hash constants
   localparam logic [31:0] HASH_ZMUL  = 32'd57;
   localparam logic [31:0] HASH_SMUL  = 32'd131;
   localparam logic [31:0] HASH_SSTEP = 32'd17;
   localparam logic [31:0] HASH_C1    = 32'd15731;
   localparam logic [31:0] HASH_C2    = 32'd789221;
   localparam logic [31:0] HASH_C3    = 32'd1376312589;
   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

   localparam int NOISE_W = 32;
   localparam int SUM_W   = 35;
   localparam int FADE_W  = 17;

endpackage

// ===== rtl/fbmvn_octave.sv =====
module fbmvn_octave #(
   parameter int PW  = 41,
   parameter int OCT = 0
) (
   input  logic                          clock,
   input  logic [fbmvn_pkg::NUM_STAGES-1:0] adv,
   input  logic signed [PW-1:0]          pos_x,
   input  logic signed [PW-1:0]          pos_z,
   input  logic [31:0]                   seed,
   output logic signed [fbmvn_pkg::NOISE_W-1:0] noise
);
   import fbmvn_pkg::*;

   // corner order: (x0,z0) (x1,z0) (x0,z1) (x1,z1); axis 0 = x, 1 = z
   logic [31:0]        n2_ff [4];
   logic [31:0]        n3_ff [4];
   logic [31:0]        nn3_ff [4];
   logic [31:0]        n4_ff [4];
   logic [31:0]        a4_ff [4];
   logic signed [31:0] c5_ff [4];
   logic signed [31:0] c6_ff [4];
   logic signed [31:0] c7_ff [4];
   logic [15:0]        t2_ff [2];
   logic [15:0]        t3_ff [2];
   logic [15:0]        tsq3_ff [2];
   logic [15:0]        t4_ff [2];
   logic [15:0]        tc4_ff [2];
   logic [15:0]        t5_ff [2];
   logic [15:0]        tc5_ff [2];
   logic [15:0]        tq5_ff [2];
   logic [15:0]        tc6_ff [2];
   logic [15:0]        tq6_ff [2];
   logic [15:0]        tf6_ff [2];
   logic [FADE_W-1:0]  s7_ff [2];
   logic signed [50:0] p8_ff [2];
   logic signed [31:0] a8_ff [2];
   logic [FADE_W-1:0]  sz8_ff;
   logic signed [32:0] r9_ff [2];
   logic [FADE_W-1:0]  sz9_ff;
   logic signed [51:0] q10_ff;
   logic signed [32:0] r10_ff;
   logic signed [NOISE_W-1:0] noise_ff;

   logic [31:0] n2_in [4];
   logic [15:0] t2_in [2];
   logic [FADE_W-1:0] s7_in [2];

   // lattice index and fraction of the position scaled by 2^OCT, then the hash mix
   always_comb begin
      logic [63:0] wx, wz;
      logic [31:0] x0, z0, sk, xc, zc, m;
      wx = 64'({{(64-PW){pos_x[PW-1]}}, pos_x}) << OCT;
      wz = 64'({{(64-PW){pos_z[PW-1]}}, pos_z}) << OCT;
      x0 = wx[47:16];
      z0 = wz[47:16];
      t2_in[0] = wx[15:0];
      t2_in[1] = wz[15:0];
      sk = (seed + 32'(HASH_SSTEP * 32'(OCT))) * HASH_SMUL;
      for (int k = 0; k < 4; k++) begin
         xc = x0 + 32'(k % 2);
         zc = z0 + 32'(k / 2);
         m  = xc + zc * HASH_ZMUL + sk;
         n2_in[k] = (m << 13) ^ m;
      end
   end

   // quintic fade 6t^5 - 15t^4 + 10t^3, clamped to [0, 1]
   // t^3 in tc6, t^4 in tq6, t^5 in tf6
   always_comb begin
      logic signed [23:0] f;
      for (int i = 0; i < 2; i++) begin
         f = 24'sd6 * $signed({8'd0, tf6_ff[i]}) + 24'sd10 * $signed({8'd0, tc6_ff[i]})
             - 24'sd15 * $signed({8'd0, tq6_ff[i]});
         if (f < 0)
            s7_in[i] = '0;
         else if (f > 24'sd65536)
            s7_in[i] = 17'd65536;
         else
            s7_in[i] = f[FADE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      logic [31:0] sq;
      if (adv[ST_HASH]) begin
         n2_ff <= n2_in;
         t2_ff <= t2_in;
      end
      if (adv[ST_SQR]) begin
         for (int k = 0; k < 4; k++) begin
            nn3_ff[k] <= n2_ff[k] * n2_ff[k];
            n3_ff[k]  <= n2_ff[k];
         end
         for (int i = 0; i < 2; i++) begin
            sq = t2_ff[i] * t2_ff[i];
            tsq3_ff[i] <= sq[31:16];
            t3_ff[i]   <= t2_ff[i];
         end
      end
      if (adv[ST_POLY]) begin
         for (int k = 0; k < 4; k++) begin
            a4_ff[k] <= nn3_ff[k] * HASH_C1 + HASH_C2;
            n4_ff[k] <= n3_ff[k];
         end
         for (int i = 0; i < 2; i++) begin
            sq = tsq3_ff[i] * t3_ff[i];
            tc4_ff[i] <= sq[31:16];
            t4_ff[i]  <= t3_ff[i];
         end
      end
      if (adv[ST_CORNER]) begin
         for (int k = 0; k < 4; k++) begin
            sq = n4_ff[k] * a4_ff[k] + HASH_C3;
            c5_ff[k] <= ONE_Q30 - $signed({1'b0, sq[30:0]});
         end
         for (int i = 0; i < 2; i++) begin
            sq = tc4_ff[i] * t4_ff[i];
            tq5_ff[i] <= sq[31:16];
            tc5_ff[i] <= tc4_ff[i];
            t5_ff[i]  <= t4_ff[i];
         end
      end
      if (adv[ST_T5]) begin
         c6_ff <= c5_ff;
         for (int i = 0; i < 2; i++) begin
            sq = tq5_ff[i] * t5_ff[i];
            tf6_ff[i] <= sq[31:16];
            tq6_ff[i] <= tq5_ff[i];
            tc6_ff[i] <= tc5_ff[i];
         end
      end
      if (adv[ST_FADE]) begin
         c7_ff <= c6_ff;
         s7_ff <= s7_in;
      end
      if (adv[ST_XMUL]) begin
         for (int i = 0; i < 2; i++) begin
            p8_ff[i] <= $signed({1'b0, s7_ff[0]})
                        * (33'(c7_ff[2*i+1]) - 33'(c7_ff[2*i]));
            a8_ff[i] <= c7_ff[2*i];
         end
         sz8_ff <= s7_ff[1];
      end
      if (adv[ST_XADD]) begin
         for (int i = 0; i < 2; i++)
            r9_ff[i] <= 33'(a8_ff[i]) + 33'(p8_ff[i] >>> 16);
         sz9_ff <= sz8_ff;
      end
      if (adv[ST_ZMUL]) begin
         q10_ff <= $signed({1'b0, sz9_ff}) * 34'(r9_ff[1] - r9_ff[0]);
         r10_ff <= r9_ff[0];
      end
      if (adv[ST_ZADD])
         noise_ff <= NOISE_W'(r10_ff + 33'(q10_ff >>> 16));
   end

   assign noise = noise_ff;

endmodule

// ===== rtl/fbm_value_noise_height_unit.sv =====
// Fractal value-noise height generator. Each request carries a world grid
// coordinate (grid_x, grid_z); the block scales it by the scale register
// (Q0.16), sums OCTAVES octaves of lattice value noise (frequency doubling,
// amplitude halving, seed + 17 per octave) and returns one signed Q1.15
// height, clamped to [-1, 1] with +1 saturating to 32767. The datapath is a
// 13-stage pipeline: one request is taken every cycle when the response
// side is not stalled. Each stage holds about one multiply or add step
// (position, hash squares, fade powers, blends), which sets the stage count.
// A stalled response only stops stages that are full; empty stages keep
// filling. The CSR port is always ready and must only be written while the
// pipeline is empty.
module fbm_value_noise_height_unit #(
   parameter int OCTAVES     = fbmvn_pkg::OCTAVES_DEF,
   parameter int COORD_WIDTH = fbmvn_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // request: grid_x [COORD_WIDTH-1:0], grid_z above it, zero padded to bytes
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   // response: height [15:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [15:0]                           rsp_tdata,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fbmvn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                           csr_data
);
   import fbmvn_pkg::*;

   localparam int PW = COORD_WIDTH + 17;   // grid * unsigned 16-bit scale

   logic [31:0] seed_ff;
   logic [15:0] scale_ff;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   logic signed [COORD_WIDTH-1:0] gx_ff, gz_ff;
   logic signed [PW-1:0]          px_ff, pz_ff;
   logic signed [NOISE_W-1:0]     noise [OCTAVES];
   logic [15:0]                   height_ff, height_in;

   // register file; writes land at once, so write only while idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SEED_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NOISE_SEED:  seed_ff  <= csr_data;
            CSR_NOISE_SCALE: scale_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // a stage moves on when it is empty or the one after it moves on
   always_comb begin
      adv[ST_OUT] = !vld_ff[ST_OUT] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--)
         adv[k] = !vld_ff[k] || adv[k+1];
      vld_in[0] = req_tvalid;
      for (int k = 1; k < NUM_STAGES; k++)
         vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++)
            if (adv[k])
               vld_ff[k] <= vld_in[k];
      end
   end

   assign req_tready = adv[ST_IN];

   // operands widened to the full product width before the multiply
   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         gx_ff <= req_tdata[COORD_WIDTH-1:0];
         gz_ff <= req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
      end
      if (adv[ST_POS]) begin
         px_ff <= PW'(gx_ff) * PW'($signed({1'b0, scale_ff}));
         pz_ff <= PW'(gz_ff) * PW'($signed({1'b0, scale_ff}));
      end
   end

   for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
      fbmvn_octave #(.PW(PW), .OCT(o)) u_oct (
         .clock (clock),
         .adv   (adv),
         .pos_x (px_ff),
         .pos_z (pz_ff),
         .seed  (seed_ff),
         .noise (noise[o])
      );
   end

   // octave sum with per-octave floor halving, clamp to [-1, 1] in Q.30
   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] shifted;
      sum = '0;
      for (int o = 0; o < OCTAVES; o++)
         sum = sum + (SUM_W'(noise[o]) >>> o);
      if (sum > SUM_W'(ONE_Q30))
         sum = SUM_W'(ONE_Q30);
      else if (sum < -SUM_W'(ONE_Q30))
         sum = -SUM_W'(ONE_Q30);
      shifted = sum >>> 15;
      if (sum == SUM_W'(ONE_Q30))
         height_in = 16'h7fff;
      else
         height_in = shifted[15:0];
   end

   always_ff @(posedge clock)
      if (adv[ST_OUT])
         height_ff <= height_in;

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = height_ff;

endmodule

// ===== rtl/fbmvn_checker.sv =====
module fbmvn_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // nothing comes out in the cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // with the output register empty the pipeline must take requests
   a_req_open: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // the first response needs the full pipeline depth after reset
   a_latency: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid [*12])
      else $error("response earlier than pipeline depth");

endmodule

bind fbm_value_noise_height_unit fbmvn_checker u_fbmvn_checker (.*);

// ===== tb/tb_fbm_value_noise_height_unit.sv =====
`timescale 1ns / 100ps

module tb_fbm_value_noise_height_unit;
   import fbmvn_pkg::*;

   localparam int CW       = 24;
   localparam int NOCT     = 4;
   localparam int REQ_W    = ((2*CW+7)/8)*8;
   localparam int N_RANDOM = 450;
   localparam int DRAIN    = 40;        // > 13-stage pipeline depth
   localparam int WATCHDOG = 20000;     // idle cycles before giving up
   localparam longint ONE  = 64'sh4000_0000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;        // grid_x [23:0], grid_z [47:24]
   logic rsp_tvalid;
   logic rsp_tready;
   logic [15:0] rsp_tdata;             // height [15:0]
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   fbm_value_noise_height_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor copy of the registers
   logic [31:0] seed_q;
   logic [15:0] scale_q;

   typedef struct packed {
      logic [15:0] height;
      logic        fixed;   // typed-in value rather than predicted
   } height_exp_type;

   height_exp_type heights_due[$];
   int mismatches;
   int idle_cycles;
   bit timed_out;

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;       // arithmetic shift is floor division
   endfunction

   function automatic longint lattice_val(logic [31:0] x, logic [31:0] y,
                                          logic [31:0] sd);
      logic [31:0] n;
      logic [31:0] v;
      n = x + y * 32'd57 + sd * 32'd131;
      n = (n << 13) ^ n;
      v = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      return ONE - longint'({32'd0, v});
   endfunction

   function automatic longint quintic(longint t);
      longint t2, t3, t4, t5, f;
      t2 = (t * t) >> 16;
      t3 = (t2 * t) >> 16;
      t4 = (t3 * t) >> 16;
      t5 = (t4 * t) >> 16;
      f = 6 * t5 + 10 * t3 - 15 * t4;
      if (f < 0) f = 0;
      if (f > 65536) f = 65536;
      return f;
   endfunction

   function automatic longint mix(longint a, longint b, longint s);
      return a + floor_sh(s * (b - a), 16);
   endfunction

   function automatic logic [15:0] predict_height(logic [CW-1:0] gx,
                                                  logic [CW-1:0] gz);
      longint px, pz, sum, n, r0, r1, sx, sz, h;
      logic [31:0] x0, z0, sd;
      px = longint'($signed(gx)) * longint'({48'd0, scale_q});
      pz = longint'($signed(gz)) * longint'({48'd0, scale_q});
      sum = 0;
      for (int o = 0; o < NOCT; o++) begin
         sd = seed_q + 32'd17 * o;
         x0 = 32'(floor_sh(px, 16));
         z0 = 32'(floor_sh(pz, 16));
         sx = quintic(px & 64'hffff);
         sz = quintic(pz & 64'hffff);
         r0 = mix(lattice_val(x0, z0, sd), lattice_val(x0 + 1, z0, sd), sx);
         r1 = mix(lattice_val(x0, z0 + 1, sd), lattice_val(x0 + 1, z0 + 1, sd), sx);
         n = mix(r0, r1, sz);
         sum += floor_sh(n, o);
         px *= 2;
         pz *= 2;
      end
      if (sum > ONE) sum = ONE;
      if (sum < -ONE) sum = -ONE;
      h = floor_sh(sum, 15);
      if (h > 32767) h = 32767;
      return h[15:0];
   endfunction

   // response checker and stall pattern
   int stall_ph;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_ph <= 0;
      end else begin
         stall_ph <= stall_ph + 1;
         // periodic quiet stretch with no stalls, otherwise random stalls
         if (stall_ph[8:7] == 2'b11) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
         if (rsp_tvalid && rsp_tready) begin
            if (heights_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response height=%0d", $signed(rsp_tdata));
            end else begin
               height_exp_type e;
               e = heights_due.pop_front();
               if (e.height !== rsp_tdata) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("height mismatch: expected %0d got %0d",
                              $signed(e.height), $signed(rsp_tdata));
               end
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1'b1;
         $display("fbm_value_noise_height_unit test failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_NOISE_SEED) seed_q = val;
      else if (idx == CSR_NOISE_SCALE) scale_q = val[15:0];
      @(posedge clock);
   endtask

   // burst/gap sender; tvalid stays high across back-to-back requests and
   // drops only when a gap starts
   int burst_left;
   task automatic send_request(logic [CW-1:0] gx, logic [CW-1:0] gz,
                               bit typed, logic [15:0] typed_h);
      height_exp_type e;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({gz, gx});
      e.height = typed ? typed_h : predict_height(gx, gz);
      e.fixed = typed;
      heights_due.insert(heights_due.size(), e);
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (heights_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   typedef struct {
      logic [CW-1:0] gx;
      logic [CW-1:0] gz;
      bit            typed;
      logic [15:0]   h;
   } grid_row_type;

   grid_row_type directed[] = '{
      '{24'd0,       24'd0,       1'b0, 16'd0},
      '{24'h7fffff,  24'h7fffff,  1'b0, 16'd0},
      '{24'h800000,  24'h800000,  1'b0, 16'd0},
      '{24'h7fffff,  24'h800000,  1'b0, 16'd0},
      '{24'h800000,  24'h7fffff,  1'b0, 16'd0},
      '{24'hffffff,  24'h000001,  1'b0, 16'd0},
      '{24'h000032,  24'hffffce,  1'b0, 16'd0},
      '{24'h555555,  24'haaaaaa,  1'b0, 16'd0},
      '{24'haaaaaa,  24'h555555,  1'b0, 16'd0},
      '{24'h000100,  24'h000200,  1'b0, 16'd0}
   };

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return CW'($urandom_range(0, 400)) - CW'(200);   // near origin
         1: return CW'($urandom);
         2: return $urandom_range(0, 1) ? 24'h7fffff - CW'($urandom_range(0, 8))
                                        : 24'h800000 + CW'($urandom_range(0, 8));
         default: return CW'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      logic [31:0] seeds[4];
      logic [15:0] scales[4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_NOISE_SEED;
      csr_data = '0;
      mismatches = 0;
      timed_out = 1'b0;
      burst_left = 0;
      seed_q = SEED_RESET;
      scale_q = SCALE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values
      foreach (directed[i])
         send_request(directed[i].gx, directed[i].gz, directed[i].typed, directed[i].h);
      wait_idle();

      // zero scale: every coordinate lands on the lattice origin
      write_reg(CSR_NOISE_SCALE, 32'hffff_0000);  // high bits ignored
      write_reg(2'd3, 32'h1234_5678);             // unused index ignored
      foreach (directed[i]) send_request(directed[i].gx, directed[i].gz, 1'b0, 16'd0);
      wait_idle();

      seeds  = '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1234abcd};
      scales = '{16'hffff, 16'd1, 16'd1311, 16'd40000};
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_NOISE_SEED, seeds[ph]);
         write_reg(CSR_NOISE_SCALE, {16'hdead, scales[ph]});
         for (int i = 0; i < N_RANDOM / 5; i++)
            send_request(rand_coord(), rand_coord(), 1'b0, 16'd0);
         wait_idle();
      end
      write_reg(CSR_NOISE_SEED, $urandom);
      write_reg(CSR_NOISE_SCALE, $urandom);
      for (int i = 0; i < N_RANDOM / 5; i++)
         send_request(rand_coord(), rand_coord(), 1'b0, 16'd0);
      wait_idle();

      if (mismatches == 0 && heights_due.size() == 0)
         $display("fbm_value_noise_height_unit test passed");
      else
         $display("fbm_value_noise_height_unit test failed");
      $finish;
   end

endmodule
